// ===== src/assert_macros.svh =====
// Assertion macros used by the scanner core's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define PLMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge.
`define PLMS_ASSERT_NEVER(lbl, expr, msg) `PLMS_ASSERT(lbl, !(expr), msg)

`endif

// ===== src/plms_pkg.sv =====
// Package with the types and constants of the palette LED matrix scanner.
`default_nettype none

package plms_pkg;

  localparam int ACTION_W   = 3;
  localparam int POS_W      = 9;
  localparam int COLOR_W    = 8;
  localparam int LED_IDX_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int GEOM_W     = 10;
  localparam int XY_ADDR_W  = 20;

  localparam logic [GEOM_W-1:0]    GEOM_MAX = 10'd512;
  localparam logic [LED_IDX_W-1:0] LED_SAT  = 12'hFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_LINEAR = 3'd0,
    ACT_SET_XY     = 3'd1,
    ACT_FILL       = 3'd2,
    ACT_PAL_WRITE  = 3'd3,
    ACT_SCAN       = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS      = 3'd0,
    CFG_ROWS         = 3'd1,
    CFG_SKIP_IN_ROW  = 3'd2,
    CFG_SKIP_PER_ROW = 3'd3,
    CFG_LED_TOTAL    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN_ADDR,
    ST_SCAN_PIX,
    ST_SCAN_OUT
  } state_e;

endpackage

`default_nettype wire

// ===== src/plms_if.sv =====
// Handshake interfaces for the action, result and configuration channels.
`default_nettype none

interface plms_in_if;
  logic                          valid;
  logic                          ready;
  logic [plms_pkg::ACTION_W-1:0] action;
  logic [plms_pkg::POS_W-1:0]    position;
  logic [plms_pkg::POS_W-1:0]    col;
  logic [plms_pkg::POS_W-1:0]    row;
  logic [plms_pkg::COLOR_W-1:0]  color_index;
  logic [plms_pkg::COLOR_W-1:0]  entry_red;
  logic [plms_pkg::COLOR_W-1:0]  entry_green;
  logic [plms_pkg::COLOR_W-1:0]  entry_blue;

  modport source (output valid, action, position, col, row, color_index,
                  entry_red, entry_green, entry_blue, input ready);
  modport sink (input valid, action, position, col, row, color_index,
                entry_red, entry_green, entry_blue, output ready);
endinterface

interface plms_out_if;
  logic                           valid;
  logic                           ready;
  logic [plms_pkg::LED_IDX_W-1:0] led_index;
  logic [plms_pkg::COLOR_W-1:0]   red;
  logic [plms_pkg::COLOR_W-1:0]   green;
  logic [plms_pkg::COLOR_W-1:0]   blue;
  logic                           frame_last;
  logic                           beyond_strip;

  modport source (output valid, led_index, red, green, blue, frame_last,
                  beyond_strip, input ready);
  modport sink (input valid, led_index, red, green, blue, frame_last,
                beyond_strip, output ready);
endinterface

interface plms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plms_pkg::CFG_IDX_W-1:0]  index;
  logic [plms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/plms_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module plms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/palette_led_matrix_scanner_core.sv =====
// Top level of the palette LED matrix scanner: frame store, palette and scan sequencer.
`default_nettype none
`include "assert_macros.svh"

// The block holds a frame store of palette indices and a palette of RGB entries, both in
// synchronous RAM, and takes one action word at a time. Pixel writes by position or by
// column and row, and palette writes, are made as the word is accepted. A scan step forms
// the address, reads the frame store, reads the palette with the pixel's index, and loads
// the result word into the output register once that register is free. A fill writes the
// first min(columns*rows, PIXEL_CAPACITY) frame store entries, one frame store write a
// cycle. After reset a clearing pass zeroes the frame store, during which no action word
// is taken; configuration writes are taken at all times. A finished result waits in the
// output register while the next action word is accepted.
module palette_led_matrix_scanner_core #(
  parameter int PIXEL_CAPACITY = 512,
  parameter int LED_CAPACITY   = 1024,
  parameter int PALETTE_DEPTH  = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  plms_in_if.sink    in_i,
  plms_out_if.source out_o,
  plms_cfg_if.sink   cfg_i
);

  import plms_pkg::*;

  localparam int PixAW = $clog2(PIXEL_CAPACITY);
  localparam int PalAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [XY_ADDR_W-1:0] PixCap   = XY_ADDR_W'(PIXEL_CAPACITY);
  localparam logic [PixAW-1:0]     PixLast  = PixAW'(PIXEL_CAPACITY - 1);
  localparam logic [COLOR_W:0]     PalDepth = (COLOR_W + 1)'(PALETTE_DEPTH);
  localparam logic [LED_IDX_W:0]   LedCap   = (LED_IDX_W + 1)'(LED_CAPACITY);

  function automatic logic [GEOM_W-1:0] geom(logic [GEOM_W-1:0] v);
    logic [GEOM_W-1:0] r;
    if (v == '0) begin
      r = GEOM_W'(1);
    end else if (v > GEOM_MAX) begin
      r = GEOM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [LED_IDX_W-1:0] sat_led(logic [LED_IDX_W:0] v);
    return (v > {1'b0, LED_SAT}) ? LED_SAT : v[LED_IDX_W-1:0];
  endfunction

  // Configuration registers
  logic [GEOM_W-1:0]     columns_q, rows_q;
  logic [7:0]            skip_in_row_q, skip_per_row_q;
  logic [CFG_DATA_W-1:0] led_total_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q      <= GEOM_W'(16);
      rows_q         <= GEOM_W'(16);
      skip_in_row_q  <= '0;
      skip_per_row_q <= '0;
      led_total_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_COLUMNS:      columns_q      <= cfg_i.data[GEOM_W-1:0];
        CFG_ROWS:         rows_q         <= cfg_i.data[GEOM_W-1:0];
        CFG_SKIP_IN_ROW:  skip_in_row_q  <= cfg_i.data[7:0];
        CFG_SKIP_PER_ROW: skip_per_row_q <= cfg_i.data[7:0];
        CFG_LED_TOTAL:    led_total_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [GEOM_W-1:0] cols, nrows, cols_m1, nrows_m1;
  assign cols     = geom(columns_q);
  assign nrows    = geom(rows_q);
  assign cols_m1  = cols - GEOM_W'(1);
  assign nrows_m1 = nrows - GEOM_W'(1);

  // Control state
  state_e state_q, state_d;
  logic   in_ready, in_acc;
  action_e act;

  assign act        = action_e'(in_i.action);
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  // Sweep used by the clearing pass and by fills
  logic [PixAW-1:0]   sweep_ptr_q, sweep_last_q;
  logic [COLOR_W-1:0] sweep_val_q;
  logic               sweep_done;
  assign sweep_done = (sweep_ptr_q == sweep_last_q);

  // Incoming pixel addresses
  logic [XY_ADDR_W-1:0] lin_addr, xy_addr, fill_n;
  logic [PixAW-1:0]     fill_last;
  logic                 lin_ok, xy_ok;

  assign lin_addr  = XY_ADDR_W'(in_i.position);
  assign xy_addr   = XY_ADDR_W'(in_i.row) * XY_ADDR_W'(cols) + XY_ADDR_W'(in_i.col);
  assign lin_ok    = lin_addr < PixCap;
  assign xy_ok     = xy_addr < PixCap;
  assign fill_n    = XY_ADDR_W'(cols) * XY_ADDR_W'(nrows);
  assign fill_last = (fill_n >= PixCap) ? PixLast : (fill_n[PixAW-1:0] - PixAW'(1));

  // Scan position and its next value
  logic [POS_W-1:0]     scan_col_q, scan_row_q, eff_col, eff_row;
  logic [LED_IDX_W-1:0] scan_led_q, eff_led, led_b;
  logic                 stale;
  logic [GEOM_W-1:0]    x_col, col_nx, row_nx;
  logic [XY_ADDR_W-1:0] scan_addr;
  logic [LED_IDX_W:0]   led_a, led_c, lt, led_total_ext;
  logic                 scan_last, scan_beyond, row_end, frame_end;

  always_comb begin
    stale   = ({1'b0, scan_col_q} >= cols) || ({1'b0, scan_row_q} >= nrows);
    eff_col = stale ? '0 : scan_col_q;
    eff_row = stale ? '0 : scan_row_q;
    eff_led = stale ? '0 : scan_led_q;

    // Odd rows run in the opposite direction.
    x_col     = eff_row[0] ? (cols_m1 - {1'b0, eff_col}) : {1'b0, eff_col};
    scan_addr = XY_ADDR_W'(eff_row) * XY_ADDR_W'(cols) + XY_ADDR_W'(x_col);
    scan_last = ({1'b0, eff_col} == cols_m1) && ({1'b0, eff_row} == nrows_m1);

    led_total_ext = (LED_IDX_W + 1)'(led_total_q);
    lt            = (led_total_ext > LedCap) ? LedCap : led_total_ext;
    scan_beyond   = {1'b0, eff_led} >= lt;

    led_a     = {1'b0, eff_led} + (LED_IDX_W + 1)'(1) + (LED_IDX_W + 1)'(skip_in_row_q);
    led_b     = sat_led(led_a);
    led_c     = {1'b0, led_b} + (LED_IDX_W + 1)'(skip_per_row_q);
    col_nx    = {1'b0, eff_col} + GEOM_W'(1);
    row_nx    = {1'b0, eff_row} + GEOM_W'(1);
    row_end   = col_nx >= cols;
    frame_end = row_nx >= nrows;
  end

  // Memory ports
  logic                      pix_we, pix_re, pal_we, pal_re;
  logic [PixAW-1:0]          pix_waddr, pix_raddr;
  logic [COLOR_W-1:0]        pix_wdata, pix_rdata;
  logic [PalAW-1:0]          pal_waddr, pal_raddr;
  logic [3*COLOR_W-1:0]      pal_wdata, pal_rdata;

  plms_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PIXEL_CAPACITY)
  ) u_pixel_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pix_wdata),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  plms_ram #(
    .WIDTH (3 * COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // Output register
  logic                 out_valid_q, out_load;
  logic [LED_IDX_W-1:0] out_led_q;
  logic [COLOR_W-1:0]   out_red_q, out_green_q, out_blue_q;
  logic                 out_last_q, out_beyond_q;

  assign out_load = (state_q == ST_SCAN_OUT) && (!out_valid_q || out_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sweep_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && act == ACT_FILL) begin
          state_d = ST_FILL;
        end else if (in_acc && act == ACT_SCAN) begin
          state_d = ST_SCAN_ADDR;
        end
      end
      ST_FILL: begin
        if (sweep_done) state_d = ST_IDLE;
      end
      ST_SCAN_ADDR: state_d = ST_SCAN_PIX;
      ST_SCAN_PIX:  state_d = ST_SCAN_OUT;
      ST_SCAN_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    pix_we    = 1'b0;
    pix_waddr = sweep_ptr_q;
    pix_wdata = sweep_val_q;
    pix_re    = 1'b0;
    pix_raddr = scan_addr[PixAW-1:0];
    pal_we    = 1'b0;
    pal_waddr = in_i.color_index[PalAW-1:0];
    pal_wdata = {in_i.entry_red, in_i.entry_green, in_i.entry_blue};
    pal_re    = 1'b0;
    pal_raddr = pix_rdata[PalAW-1:0];
    unique case (state_q) inside
      ST_CLEAR, ST_FILL: begin
        pix_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        pix_wdata = in_i.color_index;
        if (act == ACT_SET_LINEAR) begin
          pix_we    = in_acc && lin_ok;
          pix_waddr = lin_addr[PixAW-1:0];
        end else begin
          pix_we    = in_acc && (act == ACT_SET_XY) && xy_ok;
          pix_waddr = xy_addr[PixAW-1:0];
        end
        pal_we = in_acc && (act == ACT_PAL_WRITE) &&
                 ({1'b0, in_i.color_index} < PalDepth);
      end
      ST_SCAN_ADDR: pix_re = 1'b1;
      ST_SCAN_PIX:  pal_re = 1'b1;
      ST_SCAN_OUT:  ;
      default: ;
    endcase
  end

  // Scan result held while the memories are read
  logic [LED_IDX_W-1:0] pend_led_q;
  logic                 pend_last_q, pend_beyond_q, pend_oor_q, pend_black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_ptr_q  <= '0;
      sweep_last_q <= PixLast;
      sweep_val_q  <= '0;
      scan_col_q   <= '0;
      scan_row_q   <= '0;
      scan_led_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_IDLE && in_acc && act == ACT_FILL) begin
        sweep_ptr_q  <= '0;
        sweep_last_q <= fill_last;
        sweep_val_q  <= in_i.color_index;
      end else if ((state_q == ST_CLEAR || state_q == ST_FILL) && !sweep_done) begin
        sweep_ptr_q <= sweep_ptr_q + PixAW'(1);
      end

      if (state_q == ST_SCAN_ADDR) begin
        if (!row_end) begin
          scan_col_q <= col_nx[POS_W-1:0];
          scan_row_q <= eff_row;
          scan_led_q <= led_b;
        end else if (!frame_end) begin
          scan_col_q <= '0;
          scan_row_q <= row_nx[POS_W-1:0];
          scan_led_q <= sat_led(led_c);
        end else begin
          scan_col_q <= '0;
          scan_row_q <= '0;
          scan_led_q <= '0;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN_ADDR) begin
      pend_led_q    <= eff_led;
      pend_last_q   <= scan_last;
      pend_beyond_q <= scan_beyond;
      pend_oor_q    <= scan_addr >= PixCap;
    end
    if (state_q == ST_SCAN_PIX) begin
      pend_black_q <= pend_oor_q || ({1'b0, pix_rdata} >= PalDepth);
    end
    if (out_load) begin
      out_led_q    <= pend_led_q;
      out_red_q    <= pend_black_q ? '0 : pal_rdata[3*COLOR_W-1:2*COLOR_W];
      out_green_q  <= pend_black_q ? '0 : pal_rdata[2*COLOR_W-1:COLOR_W];
      out_blue_q   <= pend_black_q ? '0 : pal_rdata[COLOR_W-1:0];
      out_last_q   <= pend_last_q;
      out_beyond_q <= pend_beyond_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.led_index    = out_led_q;
  assign out_o.red          = out_red_q;
  assign out_o.green        = out_green_q;
  assign out_o.blue         = out_blue_q;
  assign out_o.frame_last   = out_last_q;
  assign out_o.beyond_strip = out_beyond_q;

  logic at_origin, sweeping, scanning;
  assign at_origin = (scan_col_q == '0) && (scan_row_q == '0);
  assign sweeping  = (state_q == ST_CLEAR) || (state_q == ST_FILL);
  assign scanning  = (state_q == ST_SCAN_ADDR) || (state_q == ST_SCAN_PIX) ||
                     (state_q == ST_SCAN_OUT);

  // The LED index is zero whenever the scan stands at the first pixel.
  `PLMS_ASSERT(a_led_zero_at_origin, at_origin |-> scan_led_q == '0, "LED not zero at origin")
  `PLMS_ASSERT(a_sweep_in_range, sweeping |-> sweep_ptr_q <= sweep_last_q, "sweep past end")
  `PLMS_ASSERT_NEVER(a_no_write_in_scan, pix_we && scanning, "frame store written in a scan")
  `PLMS_ASSERT(a_out_from_scan, $rose(out_valid_q) |-> $past(out_load), "stray result word")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the palette LED matrix scanner core.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plms_pkg::*;

  localparam int PIXEL_CAP    = 512;
  localparam int LED_CAP      = 1024;
  localparam int PAL_DEPTH    = 256;
  localparam int CLK_PERIOD   = 12;
  // A fill keeps the core busy without a result while it writes up to PIXEL_CAP entries.
  localparam int DRAIN_CYCLES = 600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic [COLOR_W-1:0]  cidx;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } action_word_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 frame_last;
    logic                 beyond_strip;
  } led_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  plms_in_if  act_bus ();
  plms_out_if led_bus ();
  plms_cfg_if cfg_bus ();

  palette_led_matrix_scanner_core #(
    .PIXEL_CAPACITY(PIXEL_CAP),
    .LED_CAPACITY  (LED_CAP),
    .PALETTE_DEPTH (PAL_DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (act_bus),
    .out_o (led_bus),
    .cfg_i (cfg_bus)
  );

  // Mirror of the core: frame store, palette, scan walk and registers.
  logic [COLOR_W-1:0]    mirror_px  [PIXEL_CAP];
  logic [23:0]           mirror_pal [PAL_DEPTH];
  int unsigned           walk_col, walk_row, walk_led;
  logic [GEOM_W-1:0]     reg_columns   = 10'd16;
  logic [GEOM_W-1:0]     reg_rows      = 10'd16;
  logic [7:0]            reg_skip_in   = 8'd0;
  logic [7:0]            reg_skip_row  = 8'd0;
  logic [CFG_DATA_W-1:0] reg_led_total = 11'd0;

  led_word_t    led_words_due [$];
  action_word_t actions_to_send [$];
  action_word_t next_action;

  // Palette entries already written, so pixel values never point at an unwritten one.
  bit                 pal_loaded [PAL_DEPTH];
  logic [COLOR_W-1:0] loaded_list [$];
  int unsigned        gen_cols, gen_rows;

  bit          in_fired, out_fired;
  int unsigned send_gap, send_calm, take_stall, take_calm;
  int unsigned cycle_count, mismatches, actions_taken, words_checked, frames_done;
  int unsigned settings_run;

  function automatic int unsigned eff_geom(logic [GEOM_W-1:0] v);
    if (v == '0) return 1;
    if (v > GEOM_MAX) return GEOM_MAX;
    return v;
  endfunction

  function automatic int unsigned clip_led(int unsigned v);
    return (v > LED_SAT) ? LED_SAT : v;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_COLUMNS:      reg_columns   = d[GEOM_W-1:0];
      CFG_ROWS:         reg_rows      = d[GEOM_W-1:0];
      CFG_SKIP_IN_ROW:  reg_skip_in   = d[7:0];
      CFG_SKIP_PER_ROW: reg_skip_row  = d[7:0];
      CFG_LED_TOTAL:    reg_led_total = d;
      default: ;
    endcase
  endfunction

  function automatic void track_action(action_word_t w);
    int unsigned cols, nrows, span, addr, x, lt;
    logic [23:0] rgb;
    led_word_t   e;
    cols  = eff_geom(reg_columns);
    nrows = eff_geom(reg_rows);
    actions_taken++;
    case (w.action)
      ACT_SET_LINEAR: begin
        if (w.position < PIXEL_CAP) mirror_px[w.position] = w.cidx;
      end
      ACT_SET_XY: begin
        addr = w.row * cols + w.col;
        if (addr < PIXEL_CAP) mirror_px[addr] = w.cidx;
      end
      ACT_FILL: begin
        span = cols * nrows;
        if (span > PIXEL_CAP) span = PIXEL_CAP;
        for (int i = 0; i < span; i++) mirror_px[i] = w.cidx;
      end
      ACT_PAL_WRITE: begin
        if (w.cidx < PAL_DEPTH) mirror_pal[w.cidx] = {w.red, w.green, w.blue};
      end
      ACT_SCAN: begin
        lt = (reg_led_total > LED_CAP) ? LED_CAP : reg_led_total;
        // A geometry change can leave the walk outside the frame: start again.
        if (walk_col >= cols || walk_row >= nrows) begin
          walk_col = 0;
          walk_row = 0;
          walk_led = 0;
        end
        x    = walk_row[0] ? (cols - 1 - walk_col) : walk_col;
        addr = walk_row * cols + x;
        rgb  = (addr < PIXEL_CAP) ? mirror_pal[mirror_px[addr]] : 24'h0;
        e.led_index    = walk_led[LED_IDX_W-1:0];
        e.red          = rgb[23:16];
        e.green        = rgb[15:8];
        e.blue         = rgb[7:0];
        e.frame_last   = (walk_col == cols - 1) && (walk_row == nrows - 1);
        e.beyond_strip = (walk_led >= lt);
        led_words_due.push_back(e);
        walk_led = clip_led(walk_led + 1 + reg_skip_in);
        walk_col++;
        if (walk_col >= cols) begin
          walk_col = 0;
          walk_led = clip_led(walk_led + reg_skip_row);
          walk_row++;
          if (walk_row >= nrows) begin
            walk_row = 0;
            walk_led = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word(led_word_t got);
    led_word_t e;
    if (led_words_due.size() == 0) begin
      $error("LED word with none expected: led_index %0d", got.led_index);
      mismatches++;
      return;
    end
    e = led_words_due.pop_front();
    check_field("led_index", e.led_index, got.led_index);
    check_field("red", e.red, got.red);
    check_field("green", e.green, got.green);
    check_field("blue", e.blue, got.blue);
    check_field("frame_last", e.frame_last, got.frame_last);
    check_field("beyond_strip", e.beyond_strip, got.beyond_strip);
    words_checked++;
    if (e.frame_last) frames_done++;
  endfunction

  // Occasionally a calm run with no waits, otherwise a random wait that is often none.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic action_word_t make_word(logic [ACTION_W-1:0] a, int unsigned pos,
                                             int unsigned c, int unsigned r,
                                             int unsigned ci, logic [23:0] rgb);
    action_word_t w;
    w.action   = a;
    w.position = POS_W'(pos);
    w.col      = POS_W'(c);
    w.row      = POS_W'(r);
    w.cidx     = COLOR_W'(ci);
    {w.red, w.green, w.blue} = rgb;
    return w;
  endfunction

  function automatic action_word_t random_word();
    action_word_t w;
    int unsigned  pick;
    w = make_word(ACT_SCAN, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 255), 24'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w.action = ACT_SCAN;
    end else if (pick < 55) begin
      w.action = ACT_SET_LINEAR;
      w.cidx   = pick_loaded();
    end else if (pick < 72) begin
      w.action = ACT_SET_XY;
      w.cidx   = pick_loaded();
      // Most addresses land inside the frame; the rest are anywhere.
      if ($urandom_range(0, 3) != 0) begin
        w.col = POS_W'($urandom_range(0, gen_cols - 1));
        w.row = POS_W'($urandom_range(0, gen_rows - 1));
      end
    end else if (pick < 92) begin
      w.action = ACT_PAL_WRITE;
    end else if (pick < 95) begin
      w.action = ACT_FILL;
      w.cidx   = pick_loaded();
    end else begin
      w.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end
    return w;
  endfunction

  function automatic void queue_word(action_word_t w);
    if (w.action == ACT_PAL_WRITE && !pal_loaded[w.cidx]) begin
      pal_loaded[w.cidx] = 1'b1;
      loaded_list.push_back(w.cidx);
    end
    actions_to_send.push_back(w);
  endfunction

  function automatic void queue_random(int unsigned n);
    action_word_t w;
    int unsigned  counted;
    counted = 0;
    while (counted < n) begin
      w = random_word();
      queue_word(w);
      if (w.action <= ACT_SCAN) counted++;
    end
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] r,
                           logic [CFG_DATA_W-1:0] si, logic [CFG_DATA_W-1:0] sr,
                           logic [CFG_DATA_W-1:0] lt);
    write_reg(CFG_COLUMNS, c);
    write_reg(CFG_ROWS, r);
    write_reg(CFG_SKIP_IN_ROW, si);
    write_reg(CFG_SKIP_PER_ROW, sr);
    write_reg(CFG_LED_TOTAL, lt);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
    gen_cols = eff_geom(c[GEOM_W-1:0]);
    gen_rows = eff_geom(r[GEOM_W-1:0]);
    settings_run++;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (actions_to_send.size() != 0 || act_bus.valid || led_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Sampling at the rising edge, before the core's registers move.
  always @(posedge clk_i) begin
    in_fired  = 1'b0;
    out_fired = 1'b0;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
      if (led_bus.valid && led_bus.ready) begin
        check_word('{led_bus.led_index, led_bus.red, led_bus.green, led_bus.blue,
                     led_bus.frame_last, led_bus.beyond_strip});
        out_fired = 1'b1;
      end
      if (act_bus.valid && act_bus.ready) begin
        track_action('{act_bus.action, act_bus.position, act_bus.col, act_bus.row,
                       act_bus.color_index, act_bus.entry_red, act_bus.entry_green,
                       act_bus.entry_blue});
        in_fired = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      act_bus.valid <= 1'b0;
    end else if (!act_bus.valid || in_fired) begin
      if (in_fired) send_gap = draw_wait(send_calm);
      if (send_gap > 0) begin
        send_gap--;
        act_bus.valid <= 1'b0;
      end else if (actions_to_send.size() > 0) begin
        next_action = actions_to_send.pop_front();
        act_bus.action      <= next_action.action;
        act_bus.position    <= next_action.position;
        act_bus.col         <= next_action.col;
        act_bus.row         <= next_action.row;
        act_bus.color_index <= next_action.cidx;
        act_bus.entry_red   <= next_action.red;
        act_bus.entry_green <= next_action.green;
        act_bus.entry_blue  <= next_action.blue;
        act_bus.valid       <= 1'b1;
      end else begin
        act_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      led_bus.ready <= 1'b0;
    end else begin
      if (out_fired) take_stall = draw_wait(take_calm);
      if (take_stall > 0) begin
        take_stall--;
        led_bus.ready <= 1'b0;
      end else begin
        led_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    act_bus.valid       = 1'b0;
    act_bus.action      = ACT_SET_LINEAR;
    act_bus.position    = '0;
    act_bus.col         = '0;
    act_bus.row         = '0;
    act_bus.color_index = '0;
    act_bus.entry_red   = '0;
    act_bus.entry_green = '0;
    act_bus.entry_blue  = '0;
    led_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_COLUMNS;
    cfg_bus.data        = '0;
    for (int i = 0; i < PIXEL_CAP; i++) mirror_px[i] = '0;
    for (int i = 0; i < PAL_DEPTH; i++) mirror_pal[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers are taken during the clearing pass, so the first setting goes in at once.
    configure(16, 16, 0, 0, 3);
    queue_word(make_word(ACT_PAL_WRITE, 0, 0, 0, 0, 24'hFF00AA));
    queue_word(make_word(ACT_PAL_WRITE, 0, 0, 0, 255, 24'h00FF55));
    queue_word(make_word(ACT_PAL_WRITE, 0, 0, 0, 1, 24'h5AA50F));
    queue_word(make_word(ACT_SCAN, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_SET_LINEAR, 511, 0, 0, 255, 24'h0));
    queue_word(make_word(ACT_SET_LINEAR, 1, 0, 0, 255, 24'h0));
    queue_word(make_word(ACT_SET_XY, 0, 15, 0, 1, 24'h0));
    // Row 1 is read mirrored, so this pixel shows up at the end of that row's walk.
    queue_word(make_word(ACT_SET_XY, 0, 0, 1, 255, 24'h0));
    queue_word(make_word(ACT_SET_XY, 0, 511, 511, 1, 24'h0));
    queue_word(make_word(ACT_SCAN, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_SPARE_FIRST, 511, 511, 511, 255, 24'hFFFFFF));
    queue_word(make_word(ACT_SPARE_FIRST + ACTION_W'(1), 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_SPARE_LAST, 511, 0, 511, 0, 24'hFFFFFF));
    queue_word(make_word(ACT_SCAN, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_SCAN, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_FILL, 0, 0, 0, 1, 24'h0));
    queue_word(make_word(ACT_SCAN, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_SET_LINEAR, 0, 0, 0, 0, 24'h0));
    queue_word(make_word(ACT_PAL_WRITE, 0, 0, 0, 0, 24'h000000));
    queue_random(300);

    // Single pixel frames, then one long row that drives the LED index into saturation.
    drain();
    configure(1, 1, 255, 255, 0);
    queue_random(60);
    drain();
    configure(512, 1, 255, 255, 2047);
    queue_random(120);
    // Zero geometry acts as one pixel and restarts the walk left in the long row.
    drain();
    configure(0, 0, 1, 2, 1024);
    queue_random(50);
    // Oversized geometry: most of the frame lies beyond the store and scans black.
    drain();
    configure(1023, 1023, 0, 0, 1);
    queue_random(120);
    drain();
    configure(7, 5, 3, 17, 100);
    queue_random(200);
    drain();
    configure(3, 2, 0, 255, 10);
    queue_random(100);
    repeat (4) begin
      drain();
      configure(CFG_DATA_W'($urandom_range(1, 40)), CFG_DATA_W'($urandom_range(1, 20)),
                CFG_DATA_W'($urandom_range(0, 255)), CFG_DATA_W'($urandom_range(0, 255)),
                CFG_DATA_W'($urandom_range(0, 1100)));
      queue_random(75);
    end
    drain();

    $display("tb_top: %0d action words taken, %0d LED words checked, %0d frame ends",
             actions_taken, words_checked, frames_done);
    $display("tb_top: %0d register settings applied, %0d mismatches",
             settings_run, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
